// ----- rtl/dree_pkg.sv -----
`default_nettype none

package dree_pkg;

   localparam int BYTE_BITS             = 8;
   localparam int NUMBER_BITS           = 16;
   localparam int DELIM_BITS            = 8;
   localparam int CSR_INDEX_BITS        = 3;
   localparam int CSR_DATA_BITS         = 16;
   localparam int POSITION_BITS_DEFAULT = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FIELD_NUMBER       = 3'd0,
      CSR_VALUE_NUMBER       = 3'd1,
      CSR_SUBVALUE_NUMBER    = 3'd2,
      CSR_FIELD_DELIMITER    = 3'd3,
      CSR_VALUE_DELIMITER    = 3'd4,
      CSR_SUBVALUE_DELIMITER = 3'd5
   } csr_index_type;

   localparam logic [NUMBER_BITS-1:0] FIELD_NUMBER_RESET       = 16'd1;
   localparam logic [NUMBER_BITS-1:0] VALUE_NUMBER_RESET       = 16'd0;
   localparam logic [NUMBER_BITS-1:0] SUBVALUE_NUMBER_RESET    = 16'd0;
   localparam logic [DELIM_BITS-1:0]  FIELD_DELIMITER_RESET    = 8'd254;
   localparam logic [DELIM_BITS-1:0]  VALUE_DELIMITER_RESET    = 8'd253;
   localparam logic [DELIM_BITS-1:0]  SUBVALUE_DELIMITER_RESET = 8'd252;

   typedef struct packed {
      logic [BYTE_BITS-1:0] record_byte;
      logic                 record_end;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 byte_present;
      logic                 extract_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [NUMBER_BITS-1:0] field_number;
      logic [NUMBER_BITS-1:0] value_number;
      logic [NUMBER_BITS-1:0] subvalue_number;
      logic [DELIM_BITS-1:0]  field_delimiter;
      logic [DELIM_BITS-1:0]  value_delimiter;
      logic [DELIM_BITS-1:0]  subvalue_delimiter;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/dree_stream_if.sv -----
`default_nettype none

interface dree_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/dree_csr.sv -----
`default_nettype none

module dree_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [dree_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [dree_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output dree_pkg::cfg_type                        cfg
);
   import dree_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FIELD_NUMBER:       cfg_in.field_number    = csr_write_data;
            CSR_VALUE_NUMBER:       cfg_in.value_number    = csr_write_data;
            CSR_SUBVALUE_NUMBER:    cfg_in.subvalue_number = csr_write_data;
            CSR_FIELD_DELIMITER:    cfg_in.field_delimiter = csr_write_data[DELIM_BITS-1:0];
            CSR_VALUE_DELIMITER:    cfg_in.value_delimiter = csr_write_data[DELIM_BITS-1:0];
            CSR_SUBVALUE_DELIMITER: begin
               cfg_in.subvalue_delimiter = csr_write_data[DELIM_BITS-1:0];
            end
            // unknown index: drop the write
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.field_number       <= FIELD_NUMBER_RESET;
         cfg_ff.value_number       <= VALUE_NUMBER_RESET;
         cfg_ff.subvalue_number    <= SUBVALUE_NUMBER_RESET;
         cfg_ff.field_delimiter    <= FIELD_DELIMITER_RESET;
         cfg_ff.value_delimiter    <= VALUE_DELIMITER_RESET;
         cfg_ff.subvalue_delimiter <= SUBVALUE_DELIMITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/dree_scan.sv -----
`default_nettype none

module dree_scan #(
   parameter int POSITION_BITS = dree_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dree_pkg::cfg_type       cfg,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire dree_pkg::req_payload_type in_payload,
   output logic                         res_valid,
   input  wire logic                    res_ready,
   output dree_pkg::rsp_payload_type    res_payload
);
   import dree_pkg::*;

   localparam int CMP_BITS = (POSITION_BITS > NUMBER_BITS) ? POSITION_BITS : NUMBER_BITS;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   logic             stage_valid_ff, stage_valid_in;
   req_payload_type  stage_word_ff;

   logic [POSITION_BITS-1:0] field_pos_ff, field_pos_in;
   logic [POSITION_BITS-1:0] value_pos_ff, value_pos_in;
   logic [POSITION_BITS-1:0] subvalue_pos_ff, subvalue_pos_in;

   logic [NUMBER_BITS-1:0] field_no;
   logic                   is_fm, is_vm, is_sm;
   logic                   value_on, subvalue_on;
   logic                   sel, last, produces, stage_fire;

   always_comb begin
      field_no = (cfg.field_number == '0) ? NUMBER_BITS'(1) : cfg.field_number;
      last     = stage_word_ff.record_end;

      is_fm = stage_word_ff.record_byte == cfg.field_delimiter;
      is_vm = !is_fm && (stage_word_ff.record_byte == cfg.value_delimiter);
      is_sm = !is_fm && !is_vm && (stage_word_ff.record_byte == cfg.subvalue_delimiter);

      value_on    = cfg.value_number != '0;
      subvalue_on = value_on && (cfg.subvalue_number != '0);

      sel = CMP_BITS'(field_pos_ff) == CMP_BITS'(field_no);
      if (value_on)
         sel = sel && (CMP_BITS'(value_pos_ff) == CMP_BITS'(cfg.value_number));
      if (subvalue_on)
         sel = sel && (CMP_BITS'(subvalue_pos_ff) == CMP_BITS'(cfg.subvalue_number));
      // marks of the selected level and above never pass
      if (is_fm || (is_vm && value_on) || (is_sm && subvalue_on))
         sel = 1'b0;

      produces   = sel || last;
      stage_fire = stage_valid_ff && (!produces || res_ready);
      in_ready   = !stage_valid_ff || stage_fire;

      res_valid                = stage_valid_ff && produces;
      res_payload.out_byte     = sel ? stage_word_ff.record_byte : '0;
      res_payload.byte_present = sel;
      res_payload.extract_done = last;
   end

   always_comb begin
      field_pos_in    = field_pos_ff;
      value_pos_in    = value_pos_ff;
      subvalue_pos_in = subvalue_pos_ff;
      if (stage_fire) begin
         if (is_fm) begin
            if (field_pos_ff != '1)
               field_pos_in = field_pos_ff + POS_ONE;
            value_pos_in    = POS_ONE;
            subvalue_pos_in = POS_ONE;
         end else if (is_vm) begin
            if (value_pos_ff != '1)
               value_pos_in = value_pos_ff + POS_ONE;
            subvalue_pos_in = POS_ONE;
         end else if (is_sm) begin
            if (subvalue_pos_ff != '1)
               subvalue_pos_in = subvalue_pos_ff + POS_ONE;
         end
         // restart for the next record
         if (last) begin
            field_pos_in    = POS_ONE;
            value_pos_in    = POS_ONE;
            subvalue_pos_in = POS_ONE;
         end
      end
      stage_valid_in = in_ready ? in_valid : stage_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         field_pos_ff    <= POS_ONE;
         value_pos_ff    <= POS_ONE;
         subvalue_pos_ff <= POS_ONE;
      end else begin
         stage_valid_ff  <= stage_valid_in;
         field_pos_ff    <= field_pos_in;
         value_pos_ff    <= value_pos_in;
         subvalue_pos_ff <= subvalue_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready)
         stage_word_ff <= in_payload;
   end

endmodule

`default_nettype wire

// ----- rtl/dree_out_reg.sv -----
`default_nettype none

module dree_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire dree_pkg::rsp_payload_type in_payload,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output dree_pkg::rsp_payload_type out_payload
);
   import dree_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type word_ff;

   // refill in the same cycle the held word is taken
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready)
         word_ff <= in_payload;
   end

   assign out_valid   = valid_ff;
   assign out_payload = word_ff;

endmodule

`default_nettype wire

// ----- rtl/delimited_record_element_extract_unit.sv -----
`default_nettype none

// Extracts one field, value or subvalue from a record of marked bytes that
// arrives one word per cycle on req_stream. Each byte goes into an input
// register, is classified against the three mark codes and the three
// position counters there, and its result is written to an output register
// on rsp_stream. The unit takes one byte every cycle while rsp_stream does
// not hold back its results. Only selected bytes and the record's final
// byte give a result, the latter with extract_done set. Registers are
// written through the csr_ port and should only change between records.
module delimited_record_element_extract_unit #(
   parameter int POSITION_BITS = dree_pkg::POSITION_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   dree_stream_if.sink                              req_stream,
   dree_stream_if.source                            rsp_stream,
   input  wire logic                                csr_write_enable,
   input  wire logic [dree_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [dree_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import dree_pkg::*;

   cfg_type         cfg;
   logic            res_valid, res_ready;
   rsp_payload_type res_payload;

   dree_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   dree_scan #(
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_stream.valid),
      .in_ready    (req_stream.ready),
      .in_payload  (req_stream.payload),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload)
   );

   dree_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (res_valid),
      .in_ready    (res_ready),
      .in_payload  (res_payload),
      .out_valid   (rsp_stream.valid),
      .out_ready   (rsp_stream.ready),
      .out_payload (rsp_stream.payload)
   );

endmodule

`default_nettype wire
